[hdl/itr_pkg.sv]
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types and constants for the interval timer register block.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned IndexW = 3;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned CountW = 2 * HalfW;

  // Item kinds; the fourth code does nothing
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  // Register word offsets; the two top offsets are unused
  typedef enum logic [IndexW-1:0] {
    REG_STATUS  = 3'd0,
    REG_CONTROL = 3'd1,
    REG_PER_LO  = 3'd2,
    REG_PER_HI  = 3'd3,
    REG_SNAP_LO = 3'd4,
    REG_SNAP_HI = 3'd5
  } reg_e;

  // Status bit positions
  localparam int unsigned StTimeoutBit = 0;
  localparam int unsigned StRunBit     = 1;

  // Control bit positions
  localparam int unsigned CtItoBit   = 0;
  localparam int unsigned CtContBit  = 1;
  localparam int unsigned CtStartBit = 2;
  localparam int unsigned CtStopBit  = 3;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [IndexW-1:0] reg_index;
    logic [HalfW-1:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [HalfW-1:0] read_data;
    logic             irq;
    logic             timed_out;
  } result_t;

endpackage

[hdl/itr_in_stage.sv]
// ----------------------------------------------------------------------------
// itr_in_stage
// Input register: holds one accepted beat until the core moves it on.
// ----------------------------------------------------------------------------
module itr_in_stage import itr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  move_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Stall only while a held beat cannot move on
  assign in_stall_o = valid_q & ~move_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (move_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hdl/itr_core.sv]
// ----------------------------------------------------------------------------
// itr_core
// Timer state and register file; applies one item per move.
// ----------------------------------------------------------------------------
module itr_core import itr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    move_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic              timeout_q, timeout_d;
  logic              running_q, running_d;
  logic              ito_q, ito_d;
  logic              cont_q, cont_d;
  logic [HalfW-1:0]  per_lo_q, per_lo_d;
  logic [HalfW-1:0]  per_hi_q, per_hi_d;
  logic [HalfW-1:0]  snap_lo_q, snap_lo_d;
  logic [HalfW-1:0]  snap_hi_q, snap_hi_d;
  logic [CountW-1:0] count_q, count_d;

  logic              expire;
  logic [HalfW-1:0]  rd;
  logic              timed_out;
  logic              run_mid;

  // Expiry when counter is zero or one
  assign expire = (count_q[CountW-1:1] == '0);

  // Compute the next state and result for the held item
  always_comb begin
    timeout_d = timeout_q;
    running_d = running_q;
    ito_d     = ito_q;
    cont_d    = cont_q;
    per_lo_d  = per_lo_q;
    per_hi_d  = per_hi_q;
    snap_lo_d = snap_lo_q;
    snap_hi_d = snap_hi_q;
    count_d   = count_q;
    rd        = '0;
    timed_out = 1'b0;
    run_mid   = running_q;

    case (item_i.func)
      FUNC_TICK: begin
        if (running_q) begin
          if (expire) begin
            timed_out = 1'b1;
            timeout_d = 1'b1;
            if (cont_q) begin
              count_d = {per_hi_q, per_lo_q};
            end else begin
              count_d   = '0;
              running_d = 1'b0;
            end
          end else begin
            count_d = count_q - CountW'(1);
          end
        end
      end
      FUNC_READ: begin
        case (item_i.reg_index)
          REG_STATUS: begin
            rd[StTimeoutBit] = timeout_q;
            rd[StRunBit]     = running_q;
          end
          REG_CONTROL: begin
            rd[CtItoBit]  = ito_q;
            rd[CtContBit] = cont_q;
          end
          REG_PER_LO:  rd = per_lo_q;
          REG_PER_HI:  rd = per_hi_q;
          REG_SNAP_LO: rd = snap_lo_q;
          REG_SNAP_HI: rd = snap_hi_q;
          default:     rd = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (item_i.reg_index)
          REG_STATUS: begin
            timeout_d = 1'b0;
          end
          REG_CONTROL: begin
            ito_d  = item_i.write_data[CtItoBit];
            cont_d = item_i.write_data[CtContBit];
            // Start acts first, then stop
            if (item_i.write_data[CtStartBit] && !running_q) begin
              count_d = {per_hi_q, per_lo_q};
              run_mid = 1'b1;
            end
            running_d = run_mid & ~item_i.write_data[CtStopBit];
          end
          REG_PER_LO: begin
            per_lo_d = item_i.write_data;
            if (running_q) begin
              count_d = {per_hi_q, item_i.write_data};
            end
          end
          REG_PER_HI: begin
            per_hi_d = item_i.write_data;
            if (running_q) begin
              count_d = {item_i.write_data, per_lo_q};
            end
          end
          REG_SNAP_LO, REG_SNAP_HI: begin
            snap_lo_d = count_q[HalfW-1:0];
            snap_hi_d = count_q[CountW-1:HalfW];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o.read_data = rd;
  assign result_o.irq       = timeout_d & ito_d;
  assign result_o.timed_out = timed_out;

  // Commit the state when the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 1'b0;
      running_q <= 1'b0;
      ito_q     <= 1'b0;
      cont_q    <= 1'b0;
      per_lo_q  <= '0;
      per_hi_q  <= '0;
      snap_lo_q <= '0;
      snap_hi_q <= '0;
      count_q   <= '0;
    end else if (move_i) begin
      timeout_q <= timeout_d;
      running_q <= running_d;
      ito_q     <= ito_d;
      cont_q    <= cont_d;
      per_lo_q  <= per_lo_d;
      per_hi_q  <= per_hi_d;
      snap_lo_q <= snap_lo_d;
      snap_hi_q <= snap_hi_d;
      count_q   <= count_d;
    end
  end

endmodule

[hdl/itr_out_stage.sv]
// ----------------------------------------------------------------------------
// itr_out_stage
// Result register: presents one result beat and holds it while stalled.
// ----------------------------------------------------------------------------
module itr_out_stage import itr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    src_valid_i,
  input  result_t result_i,
  output logic    move_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Advance when the register is free or being drained
  assign move_o = src_valid_i & (~valid_q | ~out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (move_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[hdl/interval_timer_registers.sv]
// ----------------------------------------------------------------------------
// interval_timer_registers
// Down-counting interval timer behind six 16-bit registers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one beat per item:
//   a clock tick, a register read or a register write, chosen by func_i.
//   The output channel (out_valid_o / out_stall_i) returns exactly one
//   result beat per item, in order: read data, interrupt level and expiry.
//   An accepted beat waits in the input register, then is applied and lands
//   in the result register once that register is free or being drained.
//   Throughput is one item per cycle while the output is not stalled: the
//   held item updates the timer state and the result register in the same
//   cycle, so a new beat can be taken every cycle while the output drains.
//   When the receiver stalls, the result register holds its beat, the input
//   register fills, and then in_stall_o rises until the result is taken.
//   Reset clears both stages and all timer state: stopped, no timeout,
//   interrupt disabled, one-shot mode, period, snapshot and count zero.
// ----------------------------------------------------------------------------
module interval_timer_registers import itr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FuncW-1:0]  func_i,
  input  logic [IndexW-1:0] reg_index_i,
  input  logic [HalfW-1:0]  write_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [HalfW-1:0]  read_data_o,
  output logic              irq_o,
  output logic              timed_out_o
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    move;
  result_t core_result;
  result_t out_result;

  assign in_item.func       = func_i;
  assign in_item.reg_index  = reg_index_i;
  assign in_item.write_data = write_data_i;

  // Hold the accepted beat
  itr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .move_i     (move),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // Apply the item to the timer state
  itr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .move_i   (move),
    .item_i   (held_item),
    .result_o (core_result)
  );

  // Register the result beat
  itr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (held_valid),
    .result_i    (core_result),
    .move_o      (move),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign read_data_o = out_result.read_data;
  assign irq_o       = out_result.irq;
  assign timed_out_o = out_result.timed_out;

endmodule

[bench/interval_timer_registers_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_timer_registers_tb
// Self-checking bench for the interval timer register block. Drives ticks,
// register reads and register writes through the input channel. A shadow
// copy of the timer predicts each result beat. The output channel is checked
// beat by beat, in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module interval_timer_registers_tb;
  import itr_pkg::*;

  // Codes outside the package enums
  localparam logic [FuncW-1:0]  FuncNop    = 2'd3;
  localparam logic [IndexW-1:0] RegSpareLo = 3'd6;
  localparam logic [IndexW-1:0] RegSpareHi = 3'd7;

  localparam int unsigned PhaseBeats = 340;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned MaxReports = 200;

  // Shadow timer: predicts one result per accepted beat and checks the results
  class timer_tracker;
    logic              timeout_q;
    logic              running_q;
    logic              ito_q;
    logic              cont_q;
    logic [HalfW-1:0]  per_lo_q;
    logic [HalfW-1:0]  per_hi_q;
    logic [HalfW-1:0]  snap_lo_q;
    logic [HalfW-1:0]  snap_hi_q;
    logic [CountW-1:0] count_q;
    result_t           results_due[$];
    int unsigned       mismatches;

    function new();
      timeout_q   = 1'b0;
      running_q   = 1'b0;
      ito_q       = 1'b0;
      cont_q      = 1'b0;
      per_lo_q    = '0;
      per_hi_q    = '0;
      snap_lo_q   = '0;
      snap_hi_q   = '0;
      count_q     = '0;
      mismatches  = 0;
    endfunction

    function void load_period();
      count_q   = {per_hi_q, per_lo_q};
      running_q = 1'b1;
    endfunction

    // Apply one accepted beat to the shadow state and queue its result
    function void note_item(logic [FuncW-1:0] f, logic [IndexW-1:0] idx,
                            logic [HalfW-1:0] d);
      result_t r;
      r = '0;
      case (f)
        FUNC_TICK: begin
          if (running_q) begin
            if (count_q <= 1) begin
              timeout_q   = 1'b1;
              r.timed_out = 1'b1;
              if (cont_q) begin
                load_period();
              end else begin
                count_q   = '0;
                running_q = 1'b0;
              end
            end else begin
              count_q = count_q - 1;
            end
          end
        end
        FUNC_READ: begin
          case (idx)
            REG_STATUS: begin
              r.read_data[StTimeoutBit] = timeout_q;
              r.read_data[StRunBit]     = running_q;
            end
            REG_CONTROL: begin
              r.read_data[CtItoBit]  = ito_q;
              r.read_data[CtContBit] = cont_q;
            end
            REG_PER_LO:  r.read_data = per_lo_q;
            REG_PER_HI:  r.read_data = per_hi_q;
            REG_SNAP_LO: r.read_data = snap_lo_q;
            REG_SNAP_HI: r.read_data = snap_hi_q;
            default:     r.read_data = '0;
          endcase
        end
        FUNC_WRITE: begin
          case (idx)
            REG_STATUS: timeout_q = 1'b0;
            REG_CONTROL: begin
              ito_q  = d[CtItoBit];
              cont_q = d[CtContBit];
              // start acts before stop
              if (d[CtStartBit] && !running_q) load_period();
              if (d[CtStopBit] && running_q) running_q = 1'b0;
            end
            REG_PER_LO, REG_PER_HI: begin
              if (idx == REG_PER_LO) per_lo_q = d;
              else per_hi_q = d;
              if (running_q) load_period();
            end
            REG_SNAP_LO, REG_SNAP_HI: begin
              snap_lo_q = count_q[HalfW-1:0];
              snap_hi_q = count_q[CountW-1:HalfW];
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.irq = timeout_q & ito_q;
      results_due.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(logic [HalfW-1:0] rd, logic irq, logic to);
      result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result with none due: read_data %h irq %b timed_out %b",
                   $time, rd, irq, to);
        return;
      end
      want = results_due.pop_front();
      if (rd !== want.read_data || irq !== want.irq || to !== want.timed_out) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: expected read_data %h irq %b timed_out %b, got %h %b %b",
                   $time, want.read_data, want.irq, want.timed_out, rd, irq, to);
      end
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [FuncW-1:0]  func_i       = '0;
  logic [IndexW-1:0] reg_index_i  = '0;
  logic [HalfW-1:0]  write_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [HalfW-1:0]  read_data_o;
  logic              irq_o;
  logic              timed_out_o;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  timer_tracker tracker = new();

  interval_timer_registers i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .irq_o        (irq_o),
    .timed_out_o  (timed_out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check every result beat taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(read_data_o, irq_o, timed_out_o);
  end

  function automatic logic [HalfW-1:0] ctrl_word(bit ito, bit cont, bit start, bit stop);
    logic [HalfW-1:0] w;
    w = '0;
    w[CtItoBit]   = ito;
    w[CtContBit]  = cont;
    w[CtStartBit] = start;
    w[CtStopBit]  = stop;
    return w;
  endfunction

  // Offer one beat from a falling edge, hold it until taken, note it
  task automatic push_beat(logic [FuncW-1:0] f, logic [IndexW-1:0] idx,
                           logic [HalfW-1:0] d);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    reg_index_i  <= idx;
    write_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_item(f, idx, d);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned      gap_plan[4]   = '{0, 47, 0, 26};
    int unsigned      stall_plan[4] = '{0, 0, 47, 26};
    int unsigned      pick;
    int unsigned      guard;
    logic [IndexW-1:0] idx;
    logic [HalfW-1:0]  d;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset values, stopped tick, zero period, strobes, snapshots
    push_beat(FUNC_READ, REG_STATUS, 16'hFFFF);
    push_beat(FUNC_READ, REG_CONTROL, 16'h0000);
    push_beat(FUNC_TICK, REG_STATUS, 16'h0000);
    push_beat(FUNC_WRITE, REG_CONTROL, ctrl_word(1'b1, 1'b0, 1'b1, 1'b0));
    push_beat(FUNC_TICK, REG_SNAP_HI, 16'hFFFF);
    push_beat(FUNC_READ, REG_STATUS, 16'h0000);
    push_beat(FUNC_WRITE, REG_STATUS, 16'hFFFF);
    push_beat(FUNC_WRITE, REG_PER_LO, 16'd3);
    push_beat(FUNC_WRITE, REG_CONTROL, ctrl_word(1'b1, 1'b1, 1'b1, 1'b0));
    push_beat(FUNC_WRITE, REG_CONTROL, ctrl_word(1'b1, 1'b1, 1'b1, 1'b0));
    repeat (4) push_beat(FUNC_TICK, RegSpareHi, 16'h0000);
    push_beat(FUNC_WRITE, REG_SNAP_LO, 16'hFFFF);
    push_beat(FUNC_WRITE, REG_PER_HI, 16'hFFFF);
    push_beat(FUNC_WRITE, REG_SNAP_HI, 16'h0000);
    push_beat(FUNC_READ, REG_SNAP_HI, 16'h0000);
    push_beat(FUNC_WRITE, REG_CONTROL, ctrl_word(1'b0, 1'b1, 1'b1, 1'b1));
    push_beat(FUNC_WRITE, REG_CONTROL, ctrl_word(1'b0, 1'b0, 1'b1, 1'b1));
    push_beat(FUNC_WRITE, REG_CONTROL, ctrl_word(1'b0, 1'b0, 1'b0, 1'b1));
    push_beat(FUNC_WRITE, REG_SNAP_LO, 16'h0000);
    push_beat(FUNC_READ, REG_SNAP_LO, 16'h0000);
    push_beat(FUNC_WRITE, RegSpareHi, 16'hFFFF);
    push_beat(FUNC_READ, RegSpareLo, 16'h0000);
    push_beat(FuncNop, REG_SNAP_HI, 16'hFFFF);

    // Random: mostly ticks against short periods so the counter expires often
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gap_plan[p];
      stall_pct = stall_plan[p];
      repeat (PhaseBeats) begin
        pick = $urandom_range(99);
        d    = HalfW'($urandom);
        if (pick < 55) begin
          push_beat(FUNC_TICK, IndexW'($urandom_range(7)), d);
        end else if (pick < 70) begin
          push_beat(FUNC_READ, IndexW'($urandom_range(7)), d);
        end else if (pick < 95) begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            idx = REG_CONTROL;
            d[CtStartBit] = ($urandom_range(9) < 7);
            d[CtStopBit]  = ($urandom_range(99) < 15);
          end else if (pick < 60) begin
            idx = REG_PER_LO;
            if ($urandom_range(9) < 8) d = HalfW'($urandom_range(12));
          end else if (pick < 75) begin
            idx = REG_PER_HI;
            if ($urandom_range(99) < 85) d = '0;
          end else if (pick < 85) begin
            idx = REG_STATUS;
          end else if (pick < 95) begin
            idx = $urandom_range(1) ? REG_SNAP_HI : REG_SNAP_LO;
          end else begin
            idx = $urandom_range(1) ? RegSpareHi : RegSpareLo;
          end
          push_beat(FUNC_WRITE, idx, d);
        end else begin
          push_beat(FuncNop, IndexW'($urandom_range(7)), d);
        end
      end
    end

    // Drain: drop valid, release the stall, wait for the last results
    in_valid_i <= 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    for (guard = 0; guard < DrainLimit && tracker.results_due.size() != 0; guard++)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.results_due.size() != 0) begin
      tracker.mismatches++;
      $display("%0t: %0d expected results never arrived",
               $time, tracker.results_due.size());
    end

    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
